@@ hw/rtl/fraction_reduce_defines.svh @@
// Assertion macros for the fraction_reduce block.
`ifndef FRACTION_REDUCE_DEFINES_SVH
`define FRACTION_REDUCE_DEFINES_SVH

`ifndef SYNTHESIS
`define FR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fraction_reduce assertion failed");
`define FR_ASSERT_NEVER(label, cond) \
  `FR_ASSERT(label, !(cond))
`else
`define FR_ASSERT(label, prop)
`define FR_ASSERT_NEVER(label, cond)
`endif

`endif

@@ hw/rtl/frd_pkg.sv @@
`timescale 1ns / 1ps
package frd_pkg;

  localparam int NUM_W = 32;
  localparam int DEN_W = NUM_W - 1;
  localparam int CNT_W = $clog2(NUM_W);

  typedef struct packed {
    logic signed [NUM_W-1:0] num_in;
    logic [DEN_W-1:0]        den_in;
  } frd_req_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] num_out;
    logic [DEN_W-1:0]        den_out;
  } frd_rsp_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] g;
    logic [NUM_W-1:0] m;
    logic [NUM_W-1:0] d;
  } frd_gcd_res_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [NUM_W-1:0] divisor;
  } frd_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } frd_div_rsp_t;

endpackage

@@ hw/rtl/fraction_reduce.sv @@
`timescale 1ns / 1ps
// channel | valid     | ready     | payload
// --------+-----------+-----------+----------------------------
// request | req_valid | req_ready | req (num_in, den_in)
// result  | rsp_valid | rsp_ready | rsp (num_out, den_out)
//
// A zero numerator skips the GCD and the divider and goes straight to S_DONE
// and the result register. Otherwise the binary GCD runs one step a cycle,
// then the shared serial divider runs twice, for numerator and denominator.
// Reset clears the sequencer, the GCD and divider control and rsp_valid only.
// A new request is taken while a finished result still waits in rsp.
`include "fraction_reduce_defines.svh"
module fraction_reduce (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  frd_pkg::frd_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output frd_pkg::frd_rsp_t rsp
);
  import frd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GCD  = 5'b00010,
    S_DIVN = 5'b00100,
    S_DIVD = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic             neg;
  logic [NUM_W-1:0] mag;
  logic [NUM_W-1:0] g_r;
  logic [NUM_W-1:0] d_r;
  logic [NUM_W-1:0] qn;
  logic [NUM_W-1:0] qd;
  logic             req_beat;
  logic             rsp_load;
  logic             gcd_start;
  frd_gcd_res_t     gcd_res;
  frd_div_req_t     div_req;
  frd_div_rsp_t     div_rsp;

  assign req_ready = (state == S_IDLE);
  assign req_beat  = req_valid && req_ready;
  assign mag       = req.num_in[NUM_W-1] ? NUM_W'(-req.num_in) : NUM_W'(req.num_in);
  assign gcd_start = req_beat && (req.num_in != '0);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || rsp_ready);

  assign div_req.start    = ((state == S_GCD) && gcd_res.done)
                         || ((state == S_DIVN) && div_rsp.done);
  assign div_req.dividend = (state == S_GCD) ? gcd_res.m : d_r;
  assign div_req.divisor  = (state == S_GCD) ? gcd_res.g : g_r;

  frd_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a_in  (mag),
    .b_in  ({1'b0, req.den_in}),
    .res   (gcd_res)
  );

  frd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_beat) begin
          state_next = (req.num_in == '0) ? S_DONE : S_GCD;
        end
      end
      S_GCD: begin
        if (gcd_res.done) begin
          state_next = S_DIVN;
        end
      end
      S_DIVN: begin
        if (div_rsp.done) begin
          state_next = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_beat) begin
      neg <= req.num_in[NUM_W-1];
      qn  <= '0;
      qd  <= NUM_W'(1);
    end
    if ((state == S_GCD) && gcd_res.done) begin
      g_r <= gcd_res.g;
      d_r <= gcd_res.d;
    end
    if ((state == S_DIVN) && div_rsp.done) begin
      qn <= div_rsp.quot;
    end
    if ((state == S_DIVD) && div_rsp.done) begin
      qd <= div_rsp.quot;
    end
    if (rsp_load) begin
      rsp.num_out <= neg ? NUM_W'(-qn) : qn;
      rsp.den_out <= qd[DEN_W-1:0];
    end
  end

  `FR_ASSERT(a_zero_num_skips, (req_valid && req_ready && req.num_in == '0) |=> (state == S_DONE))
  `FR_ASSERT_NEVER(a_gcd_zero, gcd_res.done && gcd_res.g == '0)
  `FR_ASSERT(a_num_quot_nonzero, ((state == S_DIVN) && div_rsp.done) |-> (div_rsp.quot != '0))

endmodule

@@ hw/rtl/frd_gcd.sv @@
`timescale 1ns / 1ps
// Binary GCD, one shift or subtract-and-shift step per cycle.
// m and d follow the common factors of two out, so the caller divides
// them by the odd part only.
module frd_gcd (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [frd_pkg::NUM_W-1:0]  a_in,
  input  logic [frd_pkg::NUM_W-1:0]  b_in,
  output frd_pkg::frd_gcd_res_t      res
);
  import frd_pkg::*;

  logic             busy;
  logic [NUM_W-1:0] a;
  logic [NUM_W-1:0] b;
  logic [NUM_W-1:0] m;
  logic [NUM_W-1:0] d;
  logic [NUM_W:0]   diff;
  logic             a_zero;
  logic             b_zero;

  assign diff   = {1'b0, a} - {1'b0, b};
  assign a_zero = (a == '0);
  assign b_zero = (b == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (a_zero || b_zero)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= a_in;
      b <= b_in;
      m <= a_in;
      d <= b_in;
    end else if (busy && !a_zero && !b_zero) begin
      priority if (!a[0] && !b[0]) begin
        a <= a >> 1;
        b <= b >> 1;
        m <= m >> 1;
        d <= d >> 1;
      end else if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (!diff[NUM_W]) begin
        a <= diff[NUM_W:1];
      end else begin
        b <= NUM_W'((~diff + 1'b1) >> 1);
      end
    end
  end

  assign res.done = busy && (a_zero || b_zero);
  assign res.g    = a_zero ? b : a;
  assign res.m    = m;
  assign res.d    = d;

endmodule

@@ hw/rtl/frd_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module frd_div (
  input  logic                  clk,
  input  logic                  rst,
  input  frd_pkg::frd_div_req_t req,
  output frd_pkg::frd_div_rsp_t rsp
);
  import frd_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] q;
  logic [NUM_W-1:0] r;
  logic [NUM_W-1:0] dv;
  logic [NUM_W:0]   rs;
  logic [NUM_W:0]   diff;
  logic             ge;

  assign rs   = {r, q[NUM_W-1]};
  assign diff = rs - {1'b0, dv};
  assign ge   = !diff[NUM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(NUM_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q  <= req.dividend;
      r  <= '0;
      dv <= req.divisor;
    end else if (busy) begin
      r <= ge ? diff[NUM_W-1:0] : rs[NUM_W-1:0];
      q <= {q[NUM_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = q;

endmodule
